[rtl/core/local_constant_propagation_assert.svh]
// Assertion macros for the constant propagation RTL.
// Depends on nothing; included inside module bodies.
`ifndef LOCAL_CONSTANT_PROPAGATION_ASSERT_SVH
`define LOCAL_CONSTANT_PROPAGATION_ASSERT_SVH
// Implication checked every clock, off during reset.
`define LCP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcp check failed");
// Next-cycle implication.
`define LCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcp check failed");
`endif

[rtl/core/lcp_pkg.sv]
// Package for local constant propagation: opcodes, forms, control structs.
// Depends on nothing.
package lcp_pkg;
    localparam int TableDepth = 16;

    localparam logic [4:0] OP_ADD    = 5'd0;
    localparam logic [4:0] OP_SUB    = 5'd1;
    localparam logic [4:0] OP_MUL    = 5'd2;
    localparam logic [4:0] OP_DIV    = 5'd3;
    localparam logic [4:0] OP_LESS   = 5'd4;
    localparam logic [4:0] OP_EQUAL  = 5'd5;
    localparam logic [4:0] OP_ASSIGN = 5'd6;
    localparam logic [4:0] OP_JZ     = 5'd7;
    localparam logic [4:0] OP_WRITE  = 5'd8;
    localparam logic [4:0] OP_ADDR   = 5'd9;
    localparam logic [4:0] OP_END_LO = 5'd10;
    localparam logic [4:0] OP_END_HI = 5'd13;
    localparam logic [4:0] OP_BEG_LO = 5'd14;
    localparam logic [4:0] OP_BEG_HI = 5'd16;

    localparam logic [1:0] FORM_VAR   = 2'd0;
    localparam logic [1:0] FORM_CONST = 2'd1;

    typedef struct packed {
        logic load;        // capture input transaction
        logic clear_pre;   // clear table before processing a BEG opcode
        logic scan;        // advance one table entry
        logic lookup_done; // finalize substitution, compute fold
        logic div_start;
        logic mul_step;
        logic commit;      // apply record/forget, possibly post clear
        logic out_load;
    } lcp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic need_div;
        logic div_done;
        logic emit;
    } lcp_stat_t;
endpackage

[rtl/core/lcp_div.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on nothing.
module lcp_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] rem_reg, rem_next, quo_reg, quo_next, den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next, busy_reg, busy_next;
    logic [32:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            den_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
                rem_next = trial[31:0];
            else
                rem_next = {rem_reg[30:0], quo_reg[31]};
            quo_next = {quo_reg[30:0], ~trial[32]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = busy_reg && (cnt_reg == 6'd31);
    assign quotient = neg_reg ? (32'd0 - quo_next) : quo_next;
endmodule

[rtl/core/lcp_ctrl.sv]
// Controller state machine for local constant propagation.
// Depends on lcp_pkg.
module lcp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             out_stall,
    output logic             out_valid,
    input  lcp_pkg::lcp_stat_t stat,
    output lcp_pkg::lcp_cmd_t  cmd
);
    import lcp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_COMM = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       out_free;

    assign out_free  = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.clear_pre = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.lookup_done = 1'b1;
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_MUL;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_COMM;
            end
            S_COMM:
            begin
                if (!stat.emit || out_free)
                begin
                    cmd.commit = 1'b1;
                    if (stat.emit)
                    begin
                        cmd.out_load = 1'b1;
                        ov_next      = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    `include "local_constant_propagation_assert.svh"
    `LCP_ASSERT_IMPL(a_accept_idle, in_valid && !in_stall, state_reg == S_IDLE)
    `LCP_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid)
    `LCP_ASSERT_IMPL(a_no_overwrite, cmd.out_load, out_free)
endmodule

[rtl/core/lcp_dp.sv]
// Datapath: constant table, scanning lookup, folding units, output register.
// Depends on lcp_pkg and lcp_div.
module lcp_dp
#(
    parameter int TABLE_DEPTH = lcp_pkg::TableDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lcp_pkg::lcp_cmd_t  cmd,
    output lcp_pkg::lcp_stat_t stat,
    input  logic [4:0]  opcode,
    input  logic [1:0]  first_form,
    input  logic [3:0]  first_level,
    input  logic [15:0] first_offset,
    input  logic signed [31:0] first_value,
    input  logic [1:0]  second_form,
    input  logic [3:0]  second_level,
    input  logic [15:0] second_offset,
    input  logic signed [31:0] second_value,
    input  logic [3:0]  dest_level,
    input  logic [15:0] dest_offset,
    output logic [4:0]  out_opcode,
    output logic [1:0]  out_first_form,
    output logic [3:0]  out_first_level,
    output logic [15:0] out_first_offset,
    output logic signed [31:0] out_first_value,
    output logic [1:0]  out_second_form,
    output logic [3:0]  out_second_level,
    output logic [15:0] out_second_offset,
    output logic signed [31:0] out_second_value,
    output logic [3:0]  out_dest_level,
    output logic [15:0] out_dest_offset,
    output logic        table_overflow
);
    import lcp_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [3:0]  lvl_mem [TABLE_DEPTH];
    logic [15:0] off_mem [TABLE_DEPTH];
    logic [31:0] val_mem [TABLE_DEPTH];

    logic [4:0]  op_reg;
    logic [1:0]  f1_reg, f2_reg;
    logic [3:0]  l1_reg, l2_reg, dl_reg;
    logic [15:0] o1_reg, o2_reg, do_reg;
    logic [31:0] v1_reg, v2_reg;
    logic [IW-1:0] idx_reg;
    logic        h1_reg, h2_reg, hk_reg, hf_reg;
    logic [IW-1:0] k_reg, fr_reg;
    logic [31:0] s1_reg, s2_reg, res_reg;
    logic        ovf;
    logic        sub1, sub2, is_arith, is_asg, tgt_ok;
    logic [3:0]  kl;
    logic [15:0] ko;
    logic [31:0] a1, a2;
    logic [1:0]  ef1, ef2;
    logic        div_done;
    logic [31:0] div_q;

    assign is_arith = (op_reg <= OP_EQUAL);
    assign is_asg   = (op_reg == OP_ASSIGN);
    assign sub1     = is_arith || (op_reg == OP_JZ) || (op_reg == OP_WRITE);
    assign sub2     = is_arith || is_asg || (op_reg == OP_ADDR);
    assign kl       = is_asg ? l1_reg : dl_reg;
    assign ko       = is_asg ? o1_reg : do_reg;
    assign stat.scan_last = (idx_reg == IW'(TABLE_DEPTH - 1));

    assign ef1 = (sub1 && f1_reg == FORM_VAR && h1_reg) ? FORM_CONST : f1_reg;
    assign ef2 = (sub2 && f2_reg == FORM_VAR && h2_reg) ? FORM_CONST : f2_reg;
    assign a1  = (sub1 && f1_reg == FORM_VAR && h1_reg) ? s1_reg : v1_reg;
    assign a2  = (sub2 && f2_reg == FORM_VAR && h2_reg) ? s2_reg : v2_reg;

    lcp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a1),
        .divisor  (a2),
        .done     (div_done),
        .quotient (div_q)
    );
    assign stat.div_done = div_done;
    assign stat.need_div = is_arith && (op_reg == OP_DIV) && (ef1 == FORM_CONST)
                           && (ef2 == FORM_CONST) && (a2 != 32'd0);

    // fold decision and record feasibility
    logic want_rec;
    assign want_rec = (is_arith && ef1 == FORM_CONST && ef2 == FORM_CONST
                       && !(op_reg == OP_DIV && a2 == 32'd0))
                      || (is_asg && ef2 == FORM_CONST);
    assign tgt_ok   = hk_reg || hf_reg;
    assign ovf      = want_rec && !tgt_ok;
    assign stat.emit = !(is_arith && want_rec && tgt_ok);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            f1_reg <= first_form;  l1_reg <= first_level;  o1_reg <= first_offset;
            v1_reg <= first_value;
            f2_reg <= second_form; l2_reg <= second_level; o2_reg <= second_offset;
            v2_reg <= second_value;
            dl_reg <= dest_level;  do_reg <= dest_offset;
        end
        if (cmd.scan)
        begin
            if (valid_reg[idx_reg] && lvl_mem[idx_reg] == l1_reg
                && off_mem[idx_reg] == o1_reg && !h1_reg)
                s1_reg <= val_mem[idx_reg];
            if (valid_reg[idx_reg] && lvl_mem[idx_reg] == l2_reg
                && off_mem[idx_reg] == o2_reg && !h2_reg)
                s2_reg <= val_mem[idx_reg];
            if (valid_reg[idx_reg] && lvl_mem[idx_reg] == kl
                && off_mem[idx_reg] == ko && !hk_reg)
                k_reg <= idx_reg;
            if (!valid_reg[idx_reg] && !hf_reg)
                fr_reg <= idx_reg;
        end
        if (cmd.lookup_done)
        begin
            case (op_reg)
                OP_ADD:   res_reg <= a1 + a2;
                OP_SUB:   res_reg <= a1 - a2;
                OP_LESS:  res_reg <= {31'd0, $signed(a1) < $signed(a2)};
                OP_EQUAL: res_reg <= {31'd0, a1 == a2};
                default:  res_reg <= a2;
            endcase
        end
        if (cmd.mul_step)
        begin
            if (op_reg == OP_MUL)
                res_reg <= a1 * a2;
            else if (op_reg == OP_DIV)
                res_reg <= div_q;
        end
        if (cmd.commit && want_rec && tgt_ok)
        begin
            if (!hk_reg)
            begin
                lvl_mem[fr_reg] <= kl;
                off_mem[fr_reg] <= ko;
                val_mem[fr_reg] <= res_reg;
            end
            else
                val_mem[k_reg] <= res_reg;
        end
        if (cmd.out_load)
        begin
            out_opcode <= op_reg;
            out_first_form <= ef1;  out_first_level <= l1_reg;
            out_first_offset <= o1_reg; out_first_value <= a1;
            out_second_form <= ef2; out_second_level <= l2_reg;
            out_second_offset <= o2_reg; out_second_value <= a2;
            out_dest_level <= dl_reg; out_dest_offset <= do_reg;
            table_overflow <= ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            idx_reg   <= '0;
            h1_reg <= 1'b0; h2_reg <= 1'b0; hk_reg <= 1'b0; hf_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                h1_reg <= 1'b0; h2_reg <= 1'b0; hk_reg <= 1'b0; hf_reg <= 1'b0;
                if (cmd.clear_pre && opcode >= OP_BEG_LO && opcode <= OP_BEG_HI)
                    valid_reg <= '0;
            end
            if (cmd.scan)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (valid_reg[idx_reg] && lvl_mem[idx_reg] == l1_reg
                    && off_mem[idx_reg] == o1_reg)
                    h1_reg <= 1'b1;
                if (valid_reg[idx_reg] && lvl_mem[idx_reg] == l2_reg
                    && off_mem[idx_reg] == o2_reg)
                    h2_reg <= 1'b1;
                if (valid_reg[idx_reg] && lvl_mem[idx_reg] == kl
                    && off_mem[idx_reg] == ko)
                    hk_reg <= 1'b1;
                if (!valid_reg[idx_reg])
                    hf_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (op_reg == OP_JZ || (op_reg >= OP_END_LO && op_reg <= OP_END_HI))
                    valid_reg <= '0;
                else if (want_rec && tgt_ok && !hk_reg)
                    valid_reg[fr_reg] <= 1'b1;
                else if (!want_rec && (is_arith || is_asg) && hk_reg)
                    valid_reg[k_reg] <= 1'b0;
            end
        end
    end
endmodule

[rtl/core/local_constant_propagation.sv]
// Channel   Handshake            Payload
// input     in_valid/in_stall    opcode .. dest_offset
// output    out_valid/out_stall  out_opcode .. table_overflow
// An item's processing time is set by the serial table scan and, when a
// division is folded, by the bit-serial divider.
// Reset clears the table valid bits and the controller; no clearing pass.
// A finished result waits in the output register; the next item is taken
// once the current one is committed.
module local_constant_propagation
#(
    parameter int TABLE_DEPTH = lcp_pkg::TableDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  opcode,
    input  logic [1:0]  first_form,
    input  logic [3:0]  first_level,
    input  logic [15:0] first_offset,
    input  logic signed [31:0] first_value,
    input  logic [1:0]  second_form,
    input  logic [3:0]  second_level,
    input  logic [15:0] second_offset,
    input  logic signed [31:0] second_value,
    input  logic [3:0]  dest_level,
    input  logic [15:0] dest_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  out_opcode,
    output logic [1:0]  out_first_form,
    output logic [3:0]  out_first_level,
    output logic [15:0] out_first_offset,
    output logic signed [31:0] out_first_value,
    output logic [1:0]  out_second_form,
    output logic [3:0]  out_second_level,
    output logic [15:0] out_second_offset,
    output logic signed [31:0] out_second_value,
    output logic [3:0]  out_dest_level,
    output logic [15:0] out_dest_offset,
    output logic        table_overflow
);
    import lcp_pkg::*;

    lcp_cmd_t  cmd;
    lcp_stat_t stat;

    lcp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    lcp_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp
    (
        .clk (clk), .rst_n (rst_n), .cmd (cmd), .stat (stat),
        .opcode (opcode), .first_form (first_form), .first_level (first_level),
        .first_offset (first_offset), .first_value (first_value),
        .second_form (second_form), .second_level (second_level),
        .second_offset (second_offset), .second_value (second_value),
        .dest_level (dest_level), .dest_offset (dest_offset),
        .out_opcode (out_opcode), .out_first_form (out_first_form),
        .out_first_level (out_first_level), .out_first_offset (out_first_offset),
        .out_first_value (out_first_value), .out_second_form (out_second_form),
        .out_second_level (out_second_level), .out_second_offset (out_second_offset),
        .out_second_value (out_second_value), .out_dest_level (out_dest_level),
        .out_dest_offset (out_dest_offset), .table_overflow (table_overflow)
    );
endmodule
